// File: sv/sensor_color_led_frame_top_defines.svh
// Assertion helpers for the frame builder checker.
`ifndef SENSOR_COLOR_LED_FRAME_TOP_DEFINES_SVH
`define SENSOR_COLOR_LED_FRAME_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SCLF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SCLF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sclf_pkg.sv
package sclf_pkg;

	localparam int PIXEL_COUNT = 25;
	localparam int IDX_W = $clog2(PIXEL_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [15:0] LUX_FS_RESET = 16'd1000;
	localparam logic [7:0] CHAN_MAX = 8'd255;

	localparam logic OP_SENSOR = 1'b0;
	localparam logic OP_ALERT = 1'b1;

	localparam logic [1:0] PAT_SQUARE = 2'd0;
	localparam logic [1:0] PAT_EXCLAIM = 2'd1;
	localparam logic [1:0] PAT_CROSS = 2'd2;
	localparam logic [1:0] PAT_OFF = 2'd3;

	// bit i is pixel i, row-major 5x5
	localparam logic [PIXEL_COUNT-1:0] SHAPE_MASK [4] = '{
		25'b11111_10001_10001_10001_11111,
		25'b00100_00100_00100_00000_00100,
		25'b10001_01010_00100_01010_10001,
		25'b00000_00000_00000_00000_00000
	};

	typedef struct packed {
		logic        operation;
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
		logic [15:0] lux_in;
		logic [1:0]  pattern;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pixel_word;
		logic        last_pixel;
	} out_item_t;

	// color is {green, red, blue}
	typedef struct packed {
		logic [23:0] color;
		logic [1:0]  pattern;
	} frame_t;

	function automatic logic pixel_lit(logic [1:0] pat, logic [IDX_W-1:0] idx);
		return SHAPE_MASK[pat][idx];
	endfunction

endpackage

// File: sv/sensor_color_led_frame_top.sv
// 5x5 LED frame builder.
// Input channel (in_valid / in_stall / in_data): one beat is one request, either a
// sensor color (red/green/blue readings plus lux) or a direct alert pattern.
// Output channel (out_valid / out_stall / out_data): every request yields 25 pixel
// beats in pixel order, last_pixel set on the 25th.
// Config: cfg_we / cfg_wdata write the lux full-scale value; write only while idle.
// In sensor mode an accepted request passes through a restoring divide, a multiply, a
// scale step, the request queue and the output register; in alert mode it goes
// straight to the queue and then the output register.
// Throughput: the output stage streams one beat per cycle while out_stall is low and
// frames are queued. A request queue of QUEUE_DEPTH entries lets the front take and
// compute the next request while the current frame streams out.
// Reset clears all control state; lux full scale returns to 1000.
// A stall on the output holds the current beat and stops the frame; the queue then
// fills and in_stall rises until room frees up.
module sensor_color_led_frame_top import sclf_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic [15:0] lux_fs_q;
	logic        push;
	frame_t      push_data;
	logic        q_full;
	logic        pop;
	frame_t      pop_data;
	logic        q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lux_fs_q <= LUX_FS_RESET;
		else if (cfg_we) lux_fs_q <= cfg_wdata;
	end

	sclf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.lux_fs    (lux_fs_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	sclf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_valid)
	);

	sclf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: sv/sclf_front.sv
module sclf_front import sclf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] lux_fs,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        push,
	output frame_t      push_data,
	input  logic        q_full
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_DIV  = 3'd1;
	localparam logic [2:0] F_MUL  = 3'd2;
	localparam logic [2:0] F_SCL  = 3'd3;
	localparam logic [2:0] F_ALT  = 3'd4;

	localparam int LANES = 4;
	localparam int LANE_LUX = 3;
	localparam logic [2:0] DIV_LAST = 3'd7;

	function automatic logic [23:0] times255(logic [15:0] v);
		return {v, 8'b0} - {8'b0, v};
	endfunction

	// x / 255 for x below 65280, where the quotient fits in 8 bits
	function automatic logic [7:0] div255(logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	logic [2:0]  state_q;
	logic [2:0]  step_q;
	logic [23:0] rem_q [LANES];
	logic [23:0] dsh_q [LANES];
	logic [7:0]  quo_q [LANES];
	logic [15:0] prod_q [3];
	logic        peak_zero_q;
	logic        lux_sat_q;
	logic [23:0] color_q;
	logic [1:0]  pat_q;

	logic        accept;
	logic [15:0] peak;
	logic [15:0] ld_den [LANES];
	logic [23:0] ld_num [LANES];
	logic [7:0]  bright;

	assign in_stall = (state_q != F_IDLE);
	assign accept = in_valid && !in_stall;

	always_comb begin
		peak = in_data.red_in;
		if (in_data.green_in > peak) peak = in_data.green_in;
		if (in_data.blue_in > peak) peak = in_data.blue_in;
		ld_den[0] = peak;
		ld_den[1] = peak;
		ld_den[2] = peak;
		ld_den[LANE_LUX] = lux_fs;
		ld_num[0] = times255(in_data.red_in);
		ld_num[1] = times255(in_data.green_in);
		ld_num[2] = times255(in_data.blue_in);
		ld_num[LANE_LUX] = times255(in_data.lux_in);
	end

	assign bright = lux_sat_q ? CHAN_MAX : quo_q[LANE_LUX];

	assign push = ((state_q == F_SCL) || (state_q == F_ALT)) && !q_full;
	assign push_data.color = (state_q == F_ALT) ? color_q :
		{div255(prod_q[1]), div255(prod_q[0]), div255(prod_q[2])};
	assign push_data.pattern = (state_q == F_ALT) ? pat_q : PAT_SQUARE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					step_q <= '0;
					if (accept) state_q <= (in_data.operation == OP_ALERT) ? F_ALT : F_DIV;
				end
				F_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == DIV_LAST) state_q <= F_MUL;
				end
				F_MUL: state_q <= F_SCL;
				F_SCL, F_ALT: begin
					if (push) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath, restoring divide one quotient bit per cycle on every lane
	always_ff @(posedge clk) begin
		if (accept) begin
			color_q <= {in_data.green_in[7:0], in_data.red_in[7:0], in_data.blue_in[7:0]};
			pat_q <= in_data.pattern;
			peak_zero_q <= (peak == 16'd0);
			lux_sat_q <= (in_data.lux_in >= lux_fs);
			for (int c = 0; c < LANES; c++) begin
				rem_q[c] <= ld_num[c];
				dsh_q[c] <= {1'b0, ld_den[c], 7'b0};
				quo_q[c] <= '0;
			end
		end else if (state_q == F_DIV) begin
			for (int c = 0; c < LANES; c++) begin
				if (rem_q[c] >= dsh_q[c]) begin
					rem_q[c] <= rem_q[c] - dsh_q[c];
					quo_q[c] <= {quo_q[c][6:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][6:0], 1'b0};
				end
				dsh_q[c] <= {1'b0, dsh_q[c][23:1]};
			end
		end
		if (state_q == F_MUL) begin
			for (int c = 0; c < 3; c++) begin
				prod_q[c] <= peak_zero_q ? 16'd0 : ({8'b0, quo_q[c]} * {8'b0, bright});
			end
		end
	end

endmodule

// File: sv/sclf_queue.sv
module sclf_queue import sclf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_data,
	output logic   full,
	input  logic   pop,
	output frame_t pop_data,
	output logic   not_empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	frame_t        entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: sv/sclf_back.sv
module sclf_back import sclf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  frame_t    q_data,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	frame_t           cur_q;
	logic             out_valid_q;
	out_item_t        out_data_q;

	logic load;
	logic last;

	assign load = busy_q && (!out_valid_q || !out_stall);
	assign last = (idx_q == LAST_IDX);
	assign pop = q_valid && (!busy_q || (load && last));

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (load) begin
				if (last) busy_q <= 1'b0;
				else idx_q <= idx_q + 1'b1;
			end
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_data;
		if (load) begin
			out_data_q.pixel_word <= pixel_lit(cur_q.pattern, idx_q) ? {cur_q.color, 8'b0} : 32'd0;
			out_data_q.last_pixel <= last;
		end
	end

endmodule

// File: sv/sclf_chk.sv
`include "sensor_color_led_frame_top_defines.svh"

module sclf_chk import sclf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input out_item_t   out_data
);

	logic             in_beat;
	logic             out_beat;
	logic             frame_done;
	logic [IDX_W-1:0] beat_cnt_q;
	logic [7:0]       pending_q;

	assign in_beat = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;
	assign frame_done = out_beat && out_data.last_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_cnt_q <= '0;
			pending_q <= '0;
		end else begin
			if (out_beat) beat_cnt_q <= (beat_cnt_q == LAST_IDX) ? '0 : beat_cnt_q + 1'b1;
			if (in_beat && !frame_done) pending_q <= pending_q + 8'd1;
			else if (frame_done && !in_beat) pending_q <= pending_q - 8'd1;
		end
	end

	`SCLF_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_data), "stalled output beat changed")
	`SCLF_ASSERT_NOW(a_last_place, out_beat,
		out_data.last_pixel == (beat_cnt_q == LAST_IDX), "frame end not on 25th beat")
	`SCLF_ASSERT_NOW(a_no_orphan, out_valid,
		pending_q != 8'd0, "pixel beat with no request outstanding")
	`SCLF_ASSERT_NOW(a_low_byte, out_valid,
		out_data.pixel_word[7:0] == 8'd0, "pixel word low byte not zero")

endmodule

bind sensor_color_led_frame_top sclf_chk u_chk (.*);
